// ===== hw/rtl/crcpf_pkg.sv =====
// shared types, constants and crc function for the crc16 packet framer
`timescale 1ns / 1ps
`default_nettype none
package crcpf_pkg;

  localparam logic       OP_START   = 1'b0;
  localparam logic       OP_PAYLOAD = 1'b1;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // one queued command for the back end
  typedef struct packed {
    logic       op;
    logic [7:0] marker;
    logic [7:0] data;     // frame type on start, payload byte on payload
    logic [7:0] length;
    logic [7:0] seq;
    logic       close;    // crc bytes follow this command
  } cmd_t;

  // crc-16/modbus update by one byte, lsb first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/crcpf_front.sv =====
// front end: accepts items, tracks frame state and issues commands
`timescale 1ns / 1ps
`default_nettype none
module crcpf_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic            op,
  input  wire logic [7:0]      frame_type,
  input  wire logic [7:0]      frame_length,
  input  wire logic [7:0]      payload_byte,
  input  wire logic            cfg_write_en,
  input  wire logic [7:0]      cfg_write_data,
  input  wire logic            q_full,
  output logic                 push,
  output crcpf_pkg::cmd_t      push_cmd
);

  logic [7:0] start_marker;
  logic [7:0] sequence_number;
  logic [7:0] bytes_remaining;
  logic       frame_open;

  logic [7:0] sequence_number_next;
  logic [7:0] bytes_remaining_next;
  logic       frame_open_next;
  logic       accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    sequence_number_next = sequence_number;
    bytes_remaining_next = bytes_remaining;
    frame_open_next      = frame_open;
    push                 = 1'b0;
    push_cmd.op          = op;
    push_cmd.marker      = start_marker;
    push_cmd.data        = (op == crcpf_pkg::OP_START) ? frame_type : payload_byte;
    push_cmd.length      = frame_length;
    push_cmd.seq         = sequence_number;
    push_cmd.close       = 1'b0;
    if (accept) begin
      if (op == crcpf_pkg::OP_START) begin
        push                 = 1'b1;
        sequence_number_next = sequence_number + 8'd1;
        push_cmd.close       = (frame_length == 8'd0);
        frame_open_next      = (frame_length != 8'd0);
        bytes_remaining_next = frame_length;
      end else if (frame_open) begin
        push                 = 1'b1;
        bytes_remaining_next = bytes_remaining - 8'd1;
        push_cmd.close       = (bytes_remaining == 8'd1);
        if (bytes_remaining == 8'd1) begin
          frame_open_next = 1'b0;
        end
      end
      // payload with no open frame is dropped
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker    <= 8'hAA;
      sequence_number <= 8'd0;
      bytes_remaining <= 8'd0;
      frame_open      <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        start_marker <= cfg_write_data;
      end
      sequence_number <= sequence_number_next;
      bytes_remaining <= bytes_remaining_next;
      frame_open      <= frame_open_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/crcpf_queue.sv =====
// small command queue between front and back end
`timescale 1ns / 1ps
`default_nettype none
module crcpf_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire crcpf_pkg::cmd_t push_cmd,
  input  wire logic            pop,
  output crcpf_pkg::cmd_t      head,
  output logic                 empty,
  output logic                 full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  crcpf_pkg::cmd_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign empty   = (count == CNT_W'(0));
  assign full    = (count == CNT_W'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (empty || full) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + CNT_W'(1)))
    else $error("queue count missed a push");

endmodule
`default_nettype wire

// ===== hw/rtl/crcpf_back.sv =====
// back end: walks each command byte by byte and computes the crc
`timescale 1ns / 1ps
`default_nettype none
module crcpf_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire crcpf_pkg::cmd_t head,
  input  wire logic            empty,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [7:0]           out_byte,
  output logic                 frame_end,
  output logic                 last_of_run
);

  localparam logic [2:0] STEP_FIRST  = 3'd0;
  localparam logic [2:0] STEP_TYPE   = 3'd1;
  localparam logic [2:0] STEP_SEQ    = 3'd2;
  localparam logic [2:0] STEP_LEN    = 3'd3;
  localparam logic [2:0] STEP_CRC_LO = 3'd4;
  localparam logic [2:0] STEP_CRC_HI = 3'd5;

  logic [2:0]  step;
  logic [15:0] crc;
  logic [2:0]  step_next;
  logic [15:0] crc_next;
  logic [7:0]  byte_next;
  logic        end_next;
  logic        last_next;
  logic        advance;

  assign advance = !empty && (!out_valid || !out_stall);
  assign pop     = advance && last_next;

  always_comb begin
    step_next = STEP_FIRST;
    crc_next  = crc;
    byte_next = head.data;
    end_next  = 1'b0;
    last_next = 1'b0;
    unique case (step)
      STEP_FIRST: begin
        if (head.op == crcpf_pkg::OP_START) begin
          byte_next = head.marker;
          crc_next  = crcpf_pkg::CRC_INIT;
          step_next = STEP_TYPE;
        end else begin
          byte_next = head.data;
          crc_next  = crcpf_pkg::crc_feed(crc, head.data);
          if (head.close) begin
            step_next = STEP_CRC_LO;
          end else begin
            last_next = 1'b1;
          end
        end
      end
      STEP_TYPE: begin
        byte_next = head.data;
        crc_next  = crcpf_pkg::crc_feed(crc, head.data);
        step_next = STEP_SEQ;
      end
      STEP_SEQ: begin
        byte_next = head.seq;
        crc_next  = crcpf_pkg::crc_feed(crc, head.seq);
        step_next = STEP_LEN;
      end
      STEP_LEN: begin
        byte_next = head.length;
        crc_next  = crcpf_pkg::crc_feed(crc, head.length);
        if (head.close) begin
          step_next = STEP_CRC_LO;
        end else begin
          last_next = 1'b1;
        end
      end
      STEP_CRC_LO: begin
        byte_next = crc[7:0];
        step_next = STEP_CRC_HI;
      end
      STEP_CRC_HI: begin
        byte_next = crc[15:8];
        crc_next  = crcpf_pkg::CRC_INIT;
        end_next  = 1'b1;
        last_next = 1'b1;
      end
      default: begin
        last_next = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= STEP_FIRST;
      crc       <= crcpf_pkg::CRC_INIT;
      out_valid <= 1'b0;
    end else if (advance) begin
      step      <= step_next;
      crc       <= crc_next;
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte    <= byte_next;
      frame_end   <= end_next;
      last_of_run <= last_next;
    end
  end

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end) |-> last_of_run)
    else $error("frame end byte not marked last");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step <= STEP_CRC_HI)
    else $error("step out of range");

  a_mid_cmd_held: assert property (@(posedge clk) disable iff (rst)
    (step != STEP_FIRST) |-> !empty)
    else $error("command left queue before its last byte");

  a_crc_reset_after_end: assert property (@(posedge clk) disable iff (rst)
    (advance && end_next) |=> (crc == crcpf_pkg::CRC_INIT && step == STEP_FIRST))
    else $error("crc not restored after frame end");

endmodule
`default_nettype wire

// ===== hw/rtl/crc16_packet_framer_unit.sv =====
// top level of the crc16 packet framer
// builds telemetry frames as a byte stream on a valid/stall output channel.
// input items: op 0 starts a frame (frame_type, frame_length), op 1 carries
// one payload byte. a start item yields marker, type, sequence, length and,
// for zero length, the crc low and high bytes; a payload item yields its byte
// and, on the last byte of the frame, the two crc bytes. payload with no open
// frame is dropped, a start abandons any open frame.
// cfg_write_en/cfg_write_data set the start marker (0xaa after reset).
// the first byte of an item passes through the queue and then the output
// register. the output register sends one byte per cycle while a command waits
// and the receiver does not stall; an item yields 1 or 3 bytes for payload,
// 4 or 6 for a start; a queue of QUEUE_DEPTH commands lets the front keep
// taking items meanwhile, and in_stall rises only when it fills.
// when the receiver stalls, the output byte holds and the queue fills behind it.
// reset (synchronous) clears the sequence number, closes any frame, restores
// the crc and empties the queue and output register.
`timescale 1ns / 1ps
`default_nettype none
module crc16_packet_framer_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       op,
  input  wire logic [7:0] frame_type,
  input  wire logic [7:0] frame_length,
  input  wire logic [7:0] payload_byte,
  input  wire logic       cfg_write_en,
  input  wire logic [7:0] cfg_write_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            frame_end,
  output logic            last_of_run
);

  crcpf_pkg::cmd_t push_cmd;
  crcpf_pkg::cmd_t head;
  logic            push;
  logic            pop;
  logic            q_empty;
  logic            q_full;

  crcpf_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .frame_type     (frame_type),
    .frame_length   (frame_length),
    .payload_byte   (payload_byte),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .q_full         (q_full),
    .push           (push),
    .push_cmd       (push_cmd)
  );

  crcpf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  crcpf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .empty       (q_empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .frame_end   (frame_end),
    .last_of_run (last_of_run)
  );

endmodule
`default_nettype wire
